// ===== hw/rtl/dfde_pkg.sv =====
package dfde_pkg;

    // frame layout
    localparam int SLOT_COUNT  = 18;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int WORD_W      = 16;
    localparam int BIT_IDX_W   = $clog2(WORD_W);
    localparam logic [SLOT_W-1:0] FIRST_SLOT = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(SLOT_COUNT - 1);

    // field widths
    localparam int THROTTLE_W = 11;
    localparam int DUTY_W     = 8;
    localparam int PERIOD_W   = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = PERIOD_W;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ONE_DUTY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_DUTY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TLM_PERIOD = 2'd2;

    // register reset values
    localparam logic [DUTY_W-1:0]   ONE_DUTY_RST   = 8'd135;
    localparam logic [DUTY_W-1:0]   ZERO_DUTY_RST  = 8'd67;
    localparam logic [PERIOD_W-1:0] TLM_PERIOD_RST = 18'd166667;

    typedef logic [WORD_W-1:0] dshot_word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // throttle, telemetry bit, then xor of the three upper nibbles
    function automatic dshot_word_t make_word(input logic [THROTTLE_W-1:0] throttle,
                                              input logic request);
        logic [11:0] payload;
        logic [3:0]  csum;
        payload = {throttle, request};
        csum    = payload[3:0] ^ payload[7:4] ^ payload[11:8];
        return {payload, csum};
    endfunction

endpackage

// ===== hw/rtl/dfde_if.sv =====
interface dfde_in_if;
    logic                              valid;
    logic                              ready;
    logic [dfde_pkg::THROTTLE_W-1:0]   throttle;

    modport source (output valid, output throttle, input ready);
    modport sink   (input valid, input throttle, output ready);
endinterface

interface dfde_out_if;
    logic                          valid;
    logic                          ready;
    logic [dfde_pkg::DUTY_W-1:0]   duty;
    logic                          last;

    modport source (output valid, output duty, output last, input ready);
    modport sink   (input valid, input duty, input last, output ready);
endinterface

interface dfde_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [dfde_pkg::CFG_IDX_W-1:0]    index;
    logic [dfde_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/dfde_fifo.sv =====
module dfde_fifo #(
    parameter int Depth = dfde_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  dfde_pkg::dshot_word_t  push_word,
    input  logic                   pop,
    output dfde_pkg::dshot_word_t  head_word,
    output dfde_pkg::queue_stat_t  stat
);
    import dfde_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    dshot_word_t      entry_reg [Depth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    assign head_word  = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CntW'(Depth));
    assign stat.empty = (count_reg == '0);

    // queue sanity
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        stat.full && !pop |-> !push)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        stat.empty |-> !pop)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(Depth))
        else $error("queue count out of range");

endmodule

// ===== hw/rtl/dfde_front.sv =====
module dfde_front (
    input  logic                             clk,
    input  logic                             rst_n,
    dfde_in_if.sink                          din,
    input  logic [dfde_pkg::PERIOD_W-1:0]    telemetry_period,
    input  dfde_pkg::queue_stat_t            stat,
    output logic                             push,
    output dfde_pkg::dshot_word_t            push_word
);
    import dfde_pkg::*;

    logic [PERIOD_W-1:0] frame_count_reg, frame_count_next;
    logic                request;

    assign din.ready = !stat.full;
    assign push      = din.valid && din.ready;

    // telemetry request once the count reaches the period
    always_comb
    begin
        request          = (frame_count_reg >= telemetry_period);
        frame_count_next = frame_count_reg;
        if (push)
        begin
            frame_count_next = request ? '0 : frame_count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
        end
        else
        begin
            frame_count_reg <= frame_count_next;
        end
    end

    assign push_word = make_word(din.throttle, request);

endmodule

// ===== hw/rtl/dfde_back.sv =====
module dfde_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dfde_pkg::dshot_word_t          head_word,
    input  dfde_pkg::queue_stat_t          stat,
    input  logic [dfde_pkg::DUTY_W-1:0]    one_duty,
    input  logic [dfde_pkg::DUTY_W-1:0]    zero_duty,
    output logic                           pop,
    dfde_out_if.source                     dout
);
    import dfde_pkg::*;

    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DUTY_W-1:0]    duty_reg, duty_next;
    logic                 last_reg, last_next;
    logic                 advance;
    logic                 load;
    logic [SLOT_W-1:0]    bit_pos;
    logic [BIT_IDX_W-1:0] bit_idx;

    // slot k carries word bit 16-k
    assign bit_pos = SLOT_W'(WORD_W) - slot_reg;
    assign bit_idx = bit_pos[BIT_IDX_W-1:0];

    assign advance = !out_valid_reg || dout.ready;
    assign load    = advance && !stat.empty;
    assign pop     = load && (slot_reg == LAST_SLOT);

    // next slot of the head word into the output register
    always_comb
    begin
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg;
        duty_next      = duty_reg;
        last_next      = last_reg;
        if (advance)
        begin
            out_valid_next = !stat.empty;
        end
        if (load)
        begin
            slot_next = (slot_reg == LAST_SLOT) ? FIRST_SLOT : slot_reg + 1'b1;
            last_next = (slot_reg == LAST_SLOT);
            if ((slot_reg == FIRST_SLOT) || (slot_reg == LAST_SLOT))
            begin
                duty_next = '0;
            end
            else
            begin
                duty_next = head_word[bit_idx] ? one_duty : zero_duty;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= FIRST_SLOT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        duty_reg <= duty_next;
        last_reg <= last_next;
    end

    assign dout.valid = out_valid_reg;
    assign dout.duty  = duty_reg;
    assign dout.last  = last_reg;

    // slot sequencing checks
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= LAST_SLOT)
        else $error("slot counter out of range");
    a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (slot_reg == FIRST_SLOT) && last_reg && out_valid_reg)
        else $error("pop without closing slot");
    a_edge_slots_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> (duty_reg == '0))
        else $error("closing slot carries nonzero duty");

endmodule

// ===== hw/rtl/dshot_frame_duty_encoder_unit.sv =====
// the throttle word is queued first, and its slots are then loaded one by one into the output register
// throughput: one slot per cycle while the receiver is ready, 18 slots per throttle word, set by the output register
// the queue holds two framed words, so input is taken while the current frame streams out
// reset: duty and period registers to defaults, frame count zero, queue empty, output idle
module dshot_frame_duty_encoder_unit #(
    parameter int QueueDepth = dfde_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    dfde_in_if.sink       din,
    dfde_out_if.source    dout,
    dfde_cfg_if.sink      cfg
);
    import dfde_pkg::*;

    logic [DUTY_W-1:0]   one_duty_reg, one_duty_next;
    logic [DUTY_W-1:0]   zero_duty_reg, zero_duty_next;
    logic [PERIOD_W-1:0] period_reg, period_next;

    logic                push;
    logic                pop;
    dshot_word_t         push_word;
    dshot_word_t         head_word;
    queue_stat_t         stat;

    // configuration register writes
    assign cfg.ready = 1'b1;

    always_comb
    begin
        one_duty_next  = one_duty_reg;
        zero_duty_next = zero_duty_reg;
        period_next    = period_reg;
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_ONE_DUTY:   one_duty_next  = cfg.data[DUTY_W-1:0];
                REG_ZERO_DUTY:  zero_duty_next = cfg.data[DUTY_W-1:0];
                REG_TLM_PERIOD: period_next    = cfg.data[PERIOD_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_duty_reg  <= ONE_DUTY_RST;
            zero_duty_reg <= ZERO_DUTY_RST;
            period_reg    <= TLM_PERIOD_RST;
        end
        else
        begin
            one_duty_reg  <= one_duty_next;
            zero_duty_reg <= zero_duty_next;
            period_reg    <= period_next;
        end
    end

    // front: telemetry decision and word build
    dfde_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .din              (din),
        .telemetry_period (period_reg),
        .stat             (stat),
        .push             (push),
        .push_word        (push_word)
    );

    // word queue
    dfde_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head_word (head_word),
        .stat      (stat)
    );

    // back: slot serializer
    dfde_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_word (head_word),
        .stat      (stat),
        .one_duty  (one_duty_reg),
        .zero_duty (zero_duty_reg),
        .pop       (pop),
        .dout      (dout)
    );

endmodule

// ===== sim/dfde_checker.sv =====
module dfde_checker (
    input  logic    clk,
    input  logic    rst_n,
    dfde_in_if      din,
    dfde_out_if     dout,
    dfde_cfg_if     cfg,
    output int      failures,
    output int      outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import dfde_pkg::*;

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              last;
    } slot_t;

    // shadow copy of the registers and the frame counter
    logic [DUTY_W-1:0]   one_duty_r;
    logic [DUTY_W-1:0]   zero_duty_r;
    logic [PERIOD_W-1:0] period_r;
    logic [PERIOD_W-1:0] frames_r;

    slot_t frame_slots[$];
    int    slot_no;

    // telemetry decision, dshot word and its eighteen compare slots
    task automatic queue_frame_slots(input logic [THROTTLE_W-1:0] throttle);
        logic              request;
        logic [11:0]       payload;
        logic [3:0]        csum;
        logic [WORD_W-1:0] dword;
        if (frames_r >= period_r) begin
            request  = 1'b1;
            frames_r = '0;
        end
        else begin
            request  = 1'b0;
            frames_r = frames_r + 1'b1;
        end
        payload = {throttle, request};
        csum    = '0;
        for (int n = 0; n < 3; n++)
            csum ^= payload[4*n +: 4];
        dword = {payload, csum};
        frame_slots.push_back('{duty: '0, last: 1'b0});
        for (int b = WORD_W - 1; b >= 0; b--)
            frame_slots.push_back('{duty: dword[b] ? one_duty_r : zero_duty_r, last: 1'b0});
        frame_slots.push_back('{duty: '0, last: 1'b1});
    endtask

    task automatic flag_failure();
        failures++;
    endtask

    // watch all three channels at each edge
    always @(posedge clk or negedge rst_n) begin
        slot_t want;
        if (!rst_n) begin
            one_duty_r  = ONE_DUTY_RST;
            zero_duty_r = ZERO_DUTY_RST;
            period_r    = TLM_PERIOD_RST;
            frames_r    = '0;
            frame_slots.delete();
            slot_no     = 0;
            failures    = 0;
            outstanding <= 0;
        end
        else begin
            // register writes
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_ONE_DUTY:   one_duty_r  = cfg.data[DUTY_W-1:0];
                    REG_ZERO_DUTY:  zero_duty_r = cfg.data[DUTY_W-1:0];
                    REG_TLM_PERIOD: period_r    = cfg.data[PERIOD_W-1:0];
                    default:        ;
                endcase
            end

            // throttle word taken
            if (din.valid && din.ready)
                queue_frame_slots(din.throttle);

            // compare slot word against oldest expectation
            if (dout.valid && dout.ready) begin
                if (frame_slots.size() == 0) begin
                    if (failures < REPORT_MAX)
                        $display("slot %0d: unexpected word, duty %0d last %0b",
                                 slot_no, dout.duty, dout.last);
                    flag_failure();
                end
                else begin
                    want = frame_slots.pop_front();
                    if (want.duty !== dout.duty || want.last !== dout.last) begin
                        if (failures < REPORT_MAX)
                            $display("slot %0d: expected duty %0d last %0b, got duty %0d last %0b",
                                     slot_no, want.duty, want.last, dout.duty, dout.last);
                        flag_failure();
                    end
                end
                slot_no++;
            end

            outstanding <= frame_slots.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dfde_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int IDLE_LIMIT      = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 20;
    localparam int RANDOM_PHASES   = 5;
    localparam int PHASE_ITEMS     = 22;

    logic clk = 1'b0;
    logic rst_n;

    int          failures;
    int          outstanding;
    int          burst_left;
    int          idle_cycles;
    int unsigned hold_off_count;

    dfde_in_if  din_if ();
    dfde_out_if dout_if ();
    dfde_cfg_if cfg_if ();

    dshot_frame_duty_encoder_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if),
        .cfg   (cfg_if)
    );

    dfde_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .din         (din_if),
        .dout        (dout_if),
        .cfg         (cfg_if),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // offer one throttle word, with bursts and random gaps in between
    task automatic offer_throttle(input logic [THROTTLE_W-1:0] throttle);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                din_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        din_if.valid    <= 1'b1;
        din_if.throttle <= throttle;
        do @(posedge clk); while (!din_if.ready);
    endtask

    // register write, valid is left high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
    endtask

    task automatic end_writes();
        cfg_if.valid <= 1'b0;
    endtask

    // stop sending and wait until every slot word has come back
    task automatic drain();
        din_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // receiver: stall pattern plus long hold-off on request
    initial begin
        int          span;
        int          mode;
        int          hold_left;
        int unsigned served;
        span      = 0;
        mode      = 0;
        hold_left = 0;
        served    = 0;
        dout_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                dout_if.ready <= 1'b0;
            end
            else if (hold_off_count != served) begin
                served    = hold_off_count;
                hold_left = HOLD_OFF_CYCLES - 1;
                dout_if.ready <= 1'b0;
            end
            else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 2);
                    span = $urandom_range(5, 60);
                end
                span--;
                case (mode)
                    0:       dout_if.ready <= 1'b1;
                    1:       dout_if.ready <= ($urandom_range(0, 3) != 0);
                    default: dout_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // watchdog on cycles with no word moving on any channel
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        logic [PERIOD_W-1:0] period;
        rst_n           <= 1'b0;
        din_if.valid    <= 1'b0;
        din_if.throttle <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= REG_ONE_DUTY;
        cfg_if.data     <= '0;
        hold_off_count  <= 0;
        burst_left = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults after reset: field extremes, alternating bits
        offer_throttle(11'h000);
        offer_throttle(11'h7FF);
        offer_throttle(11'h555);
        offer_throttle(11'h2AA);
        offer_throttle(11'h001);
        drain();

        // zero period, every frame requests telemetry; upper data bits masked
        write_reg(REG_ONE_DUTY, 18'h3FFFF);
        write_reg(REG_ZERO_DUTY, 18'h3FF00);
        write_reg(REG_TLM_PERIOD, 18'h00000);
        end_writes();
        offer_throttle(11'h000);
        offer_throttle(11'h7FF);
        offer_throttle(11'h400);
        offer_throttle(11'h001);
        drain();

        // swapped duties, period 20, a write to the unused index is ignored
        write_reg(REG_ONE_DUTY, 18'h00000);
        write_reg(REG_ZERO_DUTY, 18'h000FF);
        write_reg(REG_TLM_PERIOD, 18'd20);
        write_reg(REG_UNUSED, 18'h2A5A5);
        end_writes();
        offer_throttle(11'h7FF);
        offer_throttle(11'h000);
        offer_throttle(11'h123);
        offer_throttle(11'h6DB);
        offer_throttle(11'h492);
        offer_throttle(11'h3FF);
        offer_throttle(11'h400);
        offer_throttle(11'h0F0);
        drain();

        // period lowered below the running count requests on the next frame
        write_reg(REG_TLM_PERIOD, 18'd2);
        end_writes();
        offer_throttle(11'h155);
        offer_throttle(11'h2AA);
        offer_throttle(11'h7FF);
        drain();

        // widest period
        write_reg(REG_TLM_PERIOD, 18'h3FFFF);
        end_writes();
        offer_throttle(11'h5A5);
        offer_throttle(11'h25A);
        drain();

        // random phases, each with its own register setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0:       period = '0;
                1:       period = PERIOD_W'($urandom_range(1, 8));
                2:       period = PERIOD_W'($urandom);
                default: period = '1;
            endcase
            write_reg(REG_ONE_DUTY, CFG_DATA_W'($urandom));
            write_reg(REG_ZERO_DUTY, CFG_DATA_W'($urandom));
            write_reg(REG_TLM_PERIOD, period);
            end_writes();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == 4)
                    hold_off_count <= hold_off_count + 1;
                offer_throttle(THROTTLE_W'($urandom));
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
